[design/dnr_pkg.sv]
// ----------------------------------------------------------------------------
// dnr_pkg: shared types, constants and microcode for the decimal narrower
// Beat layouts, datapath widths, the step program and its control codes.
// ----------------------------------------------------------------------------
package dnr_pkg;

   localparam int MAX_SCALE   = 28;
   localparam int COEF_W      = 192;
   localparam int NARROW_W    = 96;
   localparam int SCALE_W     = 6;
   localparam int OUT_SCALE_W = 5;
   localparam int DIGIT_W     = 4;

   // Divide by ten, one 16-bit chunk per cycle, most significant chunk first.
   localparam int CHUNK_W     = 16;
   localparam int CHUNKS      = COEF_W / CHUNK_W;
   localparam int CHUNK_CNT_W = $clog2(CHUNKS);
   localparam int DIV_X_W     = CHUNK_W + DIGIT_W;
   localparam int RECIP_SHIFT = 23;
   localparam int PROD_W      = 2 * DIV_X_W;
   // ceil(2^23 / 10): exact quotient for every partial value below 2^22.
   localparam logic [DIV_X_W-1:0] RECIP = DIV_X_W'(838861);

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_POS_OVF = 2'd1;
   localparam logic [1:0] STATUS_NEG_OVF = 2'd2;

   typedef struct packed {
      logic [63:0]        coef_word_low;
      logic [63:0]        coef_word_mid;
      logic [63:0]        coef_word_high;
      logic [SCALE_W-1:0] in_scale;
      logic               in_negative;
   } req_type;

   typedef struct packed {
      logic [63:0]            result_low;
      logic [31:0]            result_high;
      logic [OUT_SCALE_W-1:0] out_scale;
      logic                   out_negative;
      logic [1:0]             status;
   } rsp_type;

   // Datapath actions.
   localparam int ACT_W = 4;
   localparam logic [ACT_W-1:0] ACT_NONE     = 4'd0;
   localparam logic [ACT_W-1:0] ACT_DIV_W    = 4'd1;
   localparam logic [ACT_W-1:0] ACT_STRIP    = 4'd2;
   localparam logic [ACT_W-1:0] ACT_COPY_T   = 4'd3;
   localparam logic [ACT_W-1:0] ACT_DIV_T    = 4'd4;
   localparam logic [ACT_W-1:0] ACT_T_STEP   = 4'd5;
   localparam logic [ACT_W-1:0] ACT_SET_R1   = 4'd6;
   localparam logic [ACT_W-1:0] ACT_RND_STEP = 4'd7;
   localparam logic [ACT_W-1:0] ACT_INC      = 4'd8;
   localparam logic [ACT_W-1:0] ACT_SET_R2   = 4'd9;
   localparam logic [ACT_W-1:0] ACT_ZERO     = 4'd10;
   localparam logic [ACT_W-1:0] ACT_OVF      = 4'd11;
   localparam logic [ACT_W-1:0] ACT_EMIT     = 4'd12;

   // Jump conditions.
   localparam int CND_W = 4;
   localparam logic [CND_W-1:0] CND_NEVER        = 4'd0;
   localparam logic [CND_W-1:0] CND_ALWAYS       = 4'd1;
   localparam logic [CND_W-1:0] CND_W_ZERO       = 4'd2;
   localparam logic [CND_W-1:0] CND_SCALE_ZERO   = 4'd3;
   localparam logic [CND_W-1:0] CND_REM_ZERO     = 4'd4;
   localparam logic [CND_W-1:0] CND_W_NARROW     = 4'd5;
   localparam logic [CND_W-1:0] CND_T_WIDE       = 4'd6;
   localparam logic [CND_W-1:0] CND_CNT_GT_SCALE = 4'd7;
   localparam logic [CND_W-1:0] CND_RND_MORE     = 4'd8;
   localparam logic [CND_W-1:0] CND_W_WIDE       = 4'd9;
   localparam logic [CND_W-1:0] CND_SECOND       = 4'd10;
   localparam logic [CND_W-1:0] CND_SCALE_LE_MAX = 4'd11;

   // Program steps.
   localparam int PC_W = 5;
   localparam logic [PC_W-1:0] STEP_CHK_ZERO   = 5'd0;
   localparam logic [PC_W-1:0] STEP_STRIP_CHK  = 5'd1;
   localparam logic [PC_W-1:0] STEP_STRIP_DIV  = 5'd2;
   localparam logic [PC_W-1:0] STEP_STRIP_TEST = 5'd3;
   localparam logic [PC_W-1:0] STEP_WIDE_CHK   = 5'd4;
   localparam logic [PC_W-1:0] STEP_CNT_DIV    = 5'd5;
   localparam logic [PC_W-1:0] STEP_CNT_STEP   = 5'd6;
   localparam logic [PC_W-1:0] STEP_CNT_TEST   = 5'd7;
   localparam logic [PC_W-1:0] STEP_FIT_TEST   = 5'd8;
   localparam logic [PC_W-1:0] STEP_RND1_SET   = 5'd9;
   localparam logic [PC_W-1:0] STEP_RND_DIV    = 5'd10;
   localparam logic [PC_W-1:0] STEP_RND_STEP   = 5'd11;
   localparam logic [PC_W-1:0] STEP_RND_INC    = 5'd12;
   localparam logic [PC_W-1:0] STEP_CARRY_TEST = 5'd13;
   localparam logic [PC_W-1:0] STEP_PASS_TEST  = 5'd14;
   localparam logic [PC_W-1:0] STEP_MAX_CHK    = 5'd15;
   localparam logic [PC_W-1:0] STEP_RND2_SET   = 5'd16;
   localparam logic [PC_W-1:0] STEP_ZERO       = 5'd17;
   localparam logic [PC_W-1:0] STEP_OVF        = 5'd18;
   localparam logic [PC_W-1:0] STEP_EMIT       = 5'd19;

   typedef struct packed {
      logic [ACT_W-1:0] act;
      logic [CND_W-1:0] cnd;
      logic [PC_W-1:0]  target;
   } ucode_type;

   typedef struct packed {
      logic [ACT_W-1:0] act;
      logic             fire;
      logic             div_start;
   } ctrl_type;

   typedef struct packed {
      logic w_zero;
      logic w_wide;
      logic t_wide;
      logic scale_zero;
      logic rem_zero;
      logic cnt_gt_scale;
      logic rnd_more;
      logic second;
      logic scale_le_max;
      logic div_done;
   } flags_type;

   function automatic ucode_type ucode_word(input logic [ACT_W-1:0] act,
                                            input logic [CND_W-1:0] cnd,
                                            input logic [PC_W-1:0]  target);
      ucode_type w;
      w.act    = act;
      w.cnd    = cnd;
      w.target = target;
      return w;
   endfunction

   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type w;
      case (pc)
         STEP_CHK_ZERO:   w = ucode_word(ACT_NONE,     CND_W_ZERO,       STEP_ZERO);
         STEP_STRIP_CHK:  w = ucode_word(ACT_NONE,     CND_SCALE_ZERO,   STEP_WIDE_CHK);
         STEP_STRIP_DIV:  w = ucode_word(ACT_DIV_W,    CND_NEVER,        STEP_CHK_ZERO);
         STEP_STRIP_TEST: w = ucode_word(ACT_STRIP,    CND_REM_ZERO,     STEP_STRIP_CHK);
         STEP_WIDE_CHK:   w = ucode_word(ACT_COPY_T,   CND_W_NARROW,     STEP_MAX_CHK);
         STEP_CNT_DIV:    w = ucode_word(ACT_DIV_T,    CND_NEVER,        STEP_CHK_ZERO);
         STEP_CNT_STEP:   w = ucode_word(ACT_T_STEP,   CND_NEVER,        STEP_CHK_ZERO);
         STEP_CNT_TEST:   w = ucode_word(ACT_NONE,     CND_T_WIDE,       STEP_CNT_DIV);
         STEP_FIT_TEST:   w = ucode_word(ACT_NONE,     CND_CNT_GT_SCALE, STEP_OVF);
         STEP_RND1_SET:   w = ucode_word(ACT_SET_R1,   CND_NEVER,        STEP_CHK_ZERO);
         STEP_RND_DIV:    w = ucode_word(ACT_DIV_W,    CND_NEVER,        STEP_CHK_ZERO);
         STEP_RND_STEP:   w = ucode_word(ACT_RND_STEP, CND_RND_MORE,     STEP_RND_DIV);
         STEP_RND_INC:    w = ucode_word(ACT_INC,      CND_NEVER,        STEP_CHK_ZERO);
         STEP_CARRY_TEST: w = ucode_word(ACT_NONE,     CND_W_WIDE,       STEP_OVF);
         STEP_PASS_TEST:  w = ucode_word(ACT_NONE,     CND_SECOND,       STEP_EMIT);
         STEP_MAX_CHK:    w = ucode_word(ACT_NONE,     CND_SCALE_LE_MAX, STEP_EMIT);
         STEP_RND2_SET:   w = ucode_word(ACT_SET_R2,   CND_ALWAYS,       STEP_RND_DIV);
         STEP_ZERO:       w = ucode_word(ACT_ZERO,     CND_ALWAYS,       STEP_EMIT);
         STEP_OVF:        w = ucode_word(ACT_OVF,      CND_NEVER,        STEP_CHK_ZERO);
         STEP_EMIT:       w = ucode_word(ACT_EMIT,     CND_ALWAYS,       STEP_CHK_ZERO);
         default:         w = ucode_word(ACT_EMIT,     CND_ALWAYS,       STEP_CHK_ZERO);
      endcase
      return w;
   endfunction

endpackage

[design/decimal_narrow_and_round.sv]
// ----------------------------------------------------------------------------
// decimal_narrow_and_round: narrow a 192-bit scaled decimal to 96 bits
// Strips trailing zeros, rounds half to even to fit 96 bits and the maximum
// scale, and flags overflow by sign.
// ----------------------------------------------------------------------------
// Usage
//   The req channel carries one beat per value: the 192-bit coefficient in
//   three words, its scale and its sign. req_stall is high while a value is
//   being worked on, so one value is in the block at a time. The rsp channel
//   returns one beat per request from an output register, and the next
//   request is taken while that beat still waits.
//   Every divide by ten goes through one serial divider that handles a
//   16-bit chunk per cycle, one pass for every trailing zero tested, for
//   every digit counted while the value is too wide and for every digit
//   dropped in rounding. The largest inputs count and drop 29 digits and
//   then round again to the maximum scale.
//   Reset empties the output register and returns the sequencer to idle.
//   When the receiver stalls, the finished beat holds in the output register
//   and the sequencer waits at its emit step until the register is free.
// ----------------------------------------------------------------------------
module decimal_narrow_and_round import dnr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic      busy;
   logic      req_accept;
   logic      emit_ready;
   ctrl_type  ctrl;
   flags_type flags;
   rsp_type   result;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   assign req_stall  = busy;
   assign req_accept = req_valid && !busy;
   assign emit_ready = !rsp_valid_ff || !rsp_stall;

   dnr_sequencer u_sequencer (
      .clock      (clock),
      .reset      (reset),
      .start      (req_accept),
      .emit_ready (emit_ready),
      .flags      (flags),
      .ctrl       (ctrl),
      .busy       (busy)
   );

   dnr_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .load   (req_accept),
      .req    (req_data),
      .ctrl   (ctrl),
      .flags  (flags),
      .result (result)
   );

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.fire && (ctrl.act == ACT_EMIT)) begin
         rsp_in       = result;
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> req_stall)
      else $error("request accepted but the block did not go busy");

   a_overflow_zeroed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status != STATUS_OK)) |->
         ((rsp_data.result_low == '0) && (rsp_data.result_high == '0) &&
          (rsp_data.out_scale == '0)))
      else $error("overflow beat carries a non-zero coefficient or scale");

   a_scale_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.out_scale <= OUT_SCALE_W'(MAX_SCALE)))
      else $error("result scale above the maximum");
`endif

endmodule

[design/dnr_div10.sv]
// ----------------------------------------------------------------------------
// dnr_div10: serial divide-by-ten of the 192-bit coefficient
// One 16-bit chunk per cycle through a reciprocal multiply; quotient and
// remainder are ready when done pulses.
// ----------------------------------------------------------------------------
module dnr_div10 import dnr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [COEF_W-1:0] src,
   output logic [COEF_W-1:0] quot,
   output logic [DIGIT_W-1:0] rem,
   output logic              done
);

   logic [COEF_W-1:0]      sh_ff, sh_in;
   logic [COEF_W-1:0]      q_ff, q_in;
   logic [DIGIT_W-1:0]     rem_ff, rem_in;
   logic [CHUNK_CNT_W-1:0] cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;

   logic [DIV_X_W-1:0] x;
   logic [PROD_W-1:0]  prod;
   logic [CHUNK_W-1:0] qd;
   logic [DIV_X_W-1:0] qd_times_ten;

   assign x            = {rem_ff, sh_ff[COEF_W-1 -: CHUNK_W]};
   assign prod         = PROD_W'(x) * PROD_W'(RECIP);
   assign qd           = prod[RECIP_SHIFT +: CHUNK_W];
   assign qd_times_ten = {1'b0, qd, 3'b000} + {3'b000, qd, 1'b0};

   always_comb begin
      sh_in   = sh_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         sh_in   = src;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         sh_in  = {sh_ff[COEF_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}};
         q_in   = {q_ff[COEF_W-CHUNK_W-1:0], qd};
         rem_in = DIGIT_W'(x - qd_times_ten);
         cnt_in = cnt_ff + CHUNK_CNT_W'(1);
         if (cnt_ff == CHUNK_CNT_W'(CHUNKS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      sh_ff  <= sh_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quot = q_ff;
   assign rem  = rem_ff;
   assign done = done_ff;

endmodule

[design/dnr_datapath.sv]
// ----------------------------------------------------------------------------
// dnr_datapath: coefficient, scale and rounding registers of the narrower
// Executes the action of each microcode step and reports the jump flags.
// ----------------------------------------------------------------------------
module dnr_datapath import dnr_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      load,
   input  req_type   req,
   input  ctrl_type  ctrl,
   output flags_type flags,
   output rsp_type   result
);

   logic [COEF_W-1:0]  w_ff, w_in;
   logic [COEF_W-1:0]  t_ff, t_in;
   logic [SCALE_W-1:0] scale_ff, scale_in;
   logic [SCALE_W-1:0] cnt_ff, cnt_in;
   logic [SCALE_W-1:0] rnd_cnt_ff, rnd_cnt_in;
   logic               sticky_ff, sticky_in;
   logic [DIGIT_W-1:0] last_ff, last_in;
   logic               second_ff, second_in;
   logic               neg_ff, neg_in;
   logic [1:0]         status_ff, status_in;

   logic [COEF_W-1:0]  quot;
   logic [DIGIT_W-1:0] rem;
   logic               div_done;
   logic               round_up;

   dnr_div10 u_div10 (
      .clock (clock),
      .reset (reset),
      .start (ctrl.div_start),
      .src   ((ctrl.act == ACT_DIV_T) ? t_ff : w_ff),
      .quot  (quot),
      .rem   (rem),
      .done  (div_done)
   );

   // Round half to even; every discarded digit below the last one is sticky.
   assign round_up = (last_ff > DIGIT_W'(5)) ||
                     ((last_ff == DIGIT_W'(5)) && (sticky_ff || w_ff[0]));

   always_comb begin
      w_in       = w_ff;
      t_in       = t_ff;
      scale_in   = scale_ff;
      cnt_in     = cnt_ff;
      rnd_cnt_in = rnd_cnt_ff;
      sticky_in  = sticky_ff;
      last_in    = last_ff;
      second_in  = second_ff;
      neg_in     = neg_ff;
      status_in  = status_ff;
      if (load) begin
         w_in      = {req.coef_word_high, req.coef_word_mid, req.coef_word_low};
         scale_in  = req.in_scale;
         neg_in    = req.in_negative;
         status_in = STATUS_OK;
      end else if (ctrl.fire) begin
         case (ctrl.act)
            ACT_STRIP: begin
               if (rem == '0) begin
                  w_in     = quot;
                  scale_in = scale_ff - SCALE_W'(1);
               end
            end
            ACT_COPY_T: begin
               t_in   = w_ff;
               cnt_in = '0;
            end
            ACT_T_STEP: begin
               t_in   = quot;
               cnt_in = cnt_ff + SCALE_W'(1);
            end
            ACT_SET_R1: begin
               rnd_cnt_in = cnt_ff;
               scale_in   = scale_ff - cnt_ff;
               sticky_in  = 1'b0;
               last_in    = '0;
               second_in  = 1'b0;
            end
            ACT_SET_R2: begin
               rnd_cnt_in = scale_ff - SCALE_W'(MAX_SCALE);
               scale_in   = SCALE_W'(MAX_SCALE);
               sticky_in  = 1'b0;
               last_in    = '0;
               second_in  = 1'b1;
            end
            ACT_RND_STEP: begin
               w_in = quot;
               if (rnd_cnt_ff != SCALE_W'(1)) begin
                  sticky_in = sticky_ff | (rem != '0);
               end else begin
                  last_in = rem;
               end
               rnd_cnt_in = rnd_cnt_ff - SCALE_W'(1);
            end
            ACT_INC: begin
               if (round_up) begin
                  w_in = w_ff + COEF_W'(1);
               end
            end
            ACT_ZERO: begin
               scale_in = '0;
            end
            ACT_OVF: begin
               w_in      = '0;
               scale_in  = '0;
               status_in = neg_ff ? STATUS_NEG_OVF : STATUS_POS_OVF;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      w_ff       <= w_in;
      t_ff       <= t_in;
      scale_ff   <= scale_in;
      cnt_ff     <= cnt_in;
      rnd_cnt_ff <= rnd_cnt_in;
      sticky_ff  <= sticky_in;
      last_ff    <= last_in;
      second_ff  <= second_in;
      neg_ff     <= neg_in;
      status_ff  <= status_in;
   end

   assign flags.w_zero       = (w_ff == '0);
   assign flags.w_wide       = |w_ff[COEF_W-1:NARROW_W];
   assign flags.t_wide       = |t_ff[COEF_W-1:NARROW_W];
   assign flags.scale_zero   = (scale_ff == '0);
   assign flags.rem_zero     = (rem == '0);
   assign flags.cnt_gt_scale = (cnt_ff > scale_ff);
   assign flags.rnd_more     = (rnd_cnt_ff != SCALE_W'(1));
   assign flags.second       = second_ff;
   assign flags.scale_le_max = (scale_ff <= SCALE_W'(MAX_SCALE));
   assign flags.div_done     = div_done;

   assign result.result_low   = w_ff[63:0];
   assign result.result_high  = w_ff[NARROW_W-1:64];
   assign result.out_scale    = scale_ff[OUT_SCALE_W-1:0];
   assign result.out_negative = neg_ff;
   assign result.status       = status_ff;

endmodule

[design/dnr_sequencer.sv]
// ----------------------------------------------------------------------------
// dnr_sequencer: step counter and microcode program of the narrower
// Fetches one control word per step, waits on the divider and the output
// slot, and branches on the datapath flags.
// ----------------------------------------------------------------------------
module dnr_sequencer import dnr_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   input  logic      emit_ready,
   input  flags_type flags,
   output ctrl_type  ctrl,
   output logic      busy
);

   logic [PC_W-1:0] pc_ff, pc_in;
   logic            running_ff, running_in;
   logic            issued_ff, issued_in;

   ucode_type word;
   logic      is_div;
   logic      stall_step;
   logic      fire;
   logic      taken;

   assign word   = ucode_rom(pc_ff);
   assign is_div = (word.act == ACT_DIV_W) || (word.act == ACT_DIV_T);

   always_comb begin
      case (word.cnd)
         CND_NEVER:        taken = 1'b0;
         CND_ALWAYS:       taken = 1'b1;
         CND_W_ZERO:       taken = flags.w_zero;
         CND_SCALE_ZERO:   taken = flags.scale_zero;
         CND_REM_ZERO:     taken = flags.rem_zero;
         CND_W_NARROW:     taken = !flags.w_wide;
         CND_T_WIDE:       taken = flags.t_wide;
         CND_CNT_GT_SCALE: taken = flags.cnt_gt_scale;
         CND_RND_MORE:     taken = flags.rnd_more;
         CND_W_WIDE:       taken = flags.w_wide;
         CND_SECOND:       taken = flags.second;
         CND_SCALE_LE_MAX: taken = flags.scale_le_max;
         default:          taken = 1'b0;
      endcase
   end

   // A divide step holds until its pass comes back; the emit step holds
   // until the output register can take the beat.
   assign stall_step = is_div ? !(issued_ff && flags.div_done) :
                       (word.act == ACT_EMIT) ? !emit_ready : 1'b0;
   assign fire       = running_ff && !stall_step;

   always_comb begin
      pc_in      = pc_ff;
      running_in = running_ff;
      issued_in  = issued_ff;
      if (start) begin
         pc_in      = STEP_CHK_ZERO;
         running_in = 1'b1;
         issued_in  = 1'b0;
      end else if (fire) begin
         pc_in     = taken ? word.target : pc_ff + PC_W'(1);
         issued_in = 1'b0;
         if (word.act == ACT_EMIT) begin
            running_in = 1'b0;
            pc_in      = STEP_CHK_ZERO;
         end
      end else if (running_ff && is_div) begin
         issued_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff      <= STEP_CHK_ZERO;
         running_ff <= 1'b0;
         issued_ff  <= 1'b0;
      end else begin
         pc_ff      <= pc_in;
         running_ff <= running_in;
         issued_ff  <= issued_in;
      end
   end

   assign ctrl.act       = word.act;
   assign ctrl.fire      = fire;
   assign ctrl.div_start = running_ff && is_div && !issued_ff;
   assign busy           = running_ff;

`ifndef SYNTH
   a_done_when_issued: assert property (@(posedge clock) disable iff (reset)
      flags.div_done |-> issued_ff)
      else $error("divider finished a pass that the sequencer did not issue");

   a_emit_ends_run: assert property (@(posedge clock) disable iff (reset)
      (fire && (word.act == ACT_EMIT)) |=> !running_ff)
      else $error("sequencer kept running after emitting its result");
`endif

endmodule
